@@ sv/arsl_pkg.sv @@
// arsl_pkg: shared types, command and status codes for the address range lookup.
// Used by arsl_engine and address_range_symbol_lookup; depends on nothing.
package arsl_pkg;

    localparam int DEFAULT_MAX_ROWS = 2048;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_FINAL  = 2'd2;
    localparam logic [1:0] CMD_LOOKUP = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BADNAME = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [31:0] name;
        logic [63:0] limit;
        logic [63:0] start;
    } row_t;

    typedef struct packed {
        logic [63:0] query_address;
        logic [31:0] row_name;
        logic [63:0] row_section_end;
        logic [63:0] row_start;
        logic [1:0]  cmd;
    } req_t;

    typedef struct packed {
        logic [63:0] hit_offset;
        logic [31:0] hit_name;
        logic [2:0]  status;
    } res_t;

endpackage

@@ sv/arsl_engine.sv @@
// arsl_engine: row memory plus the sequencer for load, sort, tighten and lookup.
// Depends on arsl_pkg.
module arsl_engine #(
    parameter int MAX_ROWS = arsl_pkg::DEFAULT_MAX_ROWS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  arsl_pkg::req_t  req,
    input  logic [31:0]     strings_size,
    input  logic            slot_free,
    output logic            busy,
    output logic            done,
    output arsl_pkg::res_t  res
);
    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ROWS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RK   = 4'd1;
    localparam logic [3:0] S_WK   = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_PL   = 4'd4;
    localparam logic [3:0] S_T0   = 4'd5;
    localparam logic [3:0] S_T1   = 4'd6;
    localparam logic [3:0] S_T2   = 4'd7;
    localparam logic [3:0] S_L0   = 4'd8;
    localparam logic [3:0] S_LC   = 4'd9;
    localparam logic [3:0] S_LF   = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    arsl_pkg::row_t mem [MAX_ROWS];
    arsl_pkg::row_t rd_data;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    arsl_pkg::row_t wr_data;
    logic [AW-1:0]  rd_addr;

    logic [3:0]     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           pub_reg, pub_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [AW-1:0]  lo_reg, lo_next;
    logic [AW-1:0]  hi_reg, hi_next;
    logic [AW-1:0]  mid_reg, mid_next;
    arsl_pkg::row_t key_reg, key_next;
    logic [63:0]    addr_reg, addr_next;
    arsl_pkg::res_t res_reg, res_next;

    logic [AW-1:0]  nlo, nhi, nmid;
    logic [AW:0]    span;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    // next probe of the floor search from the updated bounds
    always_comb
    begin
        nlo = lo_reg;
        nhi = hi_reg;
        if (state_reg == S_LC)
        begin
            if (rd_data.start <= addr_reg)
            begin
                nlo = mid_reg;
            end
            else
            begin
                nhi = mid_reg - AW'(1);
            end
        end
        span = {1'b0, nhi} - {1'b0, nlo} + (AW+1)'(1);
        nmid = nlo + span[AW:1];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pub_next   = pub_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        addr_next  = addr_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = key_reg;
        rd_addr    = '0;
        done       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next  = '0;
                    addr_next = req.query_address;
                    state_next = S_DONE;
                    unique case (req.cmd)
                        arsl_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            pub_next   = 1'b0;
                        end
                        arsl_pkg::CMD_LOAD:
                        begin
                            if (count_reg >= MAX_CNT)
                            begin
                                res_next.status = arsl_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = count_reg[AW-1:0];
                                wr_data.start = req.row_start;
                                wr_data.limit = req.row_section_end;
                                wr_data.name  = req.row_name;
                                count_next    = count_reg + CW'(1);
                                pub_next      = 1'b0;
                            end
                        end
                        arsl_pkg::CMD_FINAL:
                        begin
                            if (count_reg == '0)
                            begin
                                pub_next        = 1'b0;
                                res_next.status = arsl_pkg::ST_EMPTY;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                pub_next = 1'b1;
                            end
                            else
                            begin
                                i_next     = CW'(1);
                                state_next = S_RK;
                            end
                        end
                        default:
                        begin
                            if (!pub_reg || count_reg == '0)
                            begin
                                res_next.status = arsl_pkg::ST_MISS;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                lo_next    = '0;
                                hi_next    = AW'(count_reg - CW'(1));
                                state_next = S_L0;
                            end
                        end
                    endcase
                end
            end
            S_RK:
            begin
                rd_addr    = i_reg[AW-1:0];
                state_next = S_WK;
            end
            S_WK:
            begin
                key_next   = rd_data;
                j_next     = i_reg;
                rd_addr    = AW'(i_reg - CW'(1));
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // shift the larger row up one place, or stop at the insert point
                if (rd_data.start > key_reg.start)
                begin
                    wr_en   = 1'b1;
                    wr_addr = j_reg[AW-1:0];
                    wr_data = rd_data;
                    j_next  = j_reg - CW'(1);
                    if (j_reg == CW'(1))
                    begin
                        state_next = S_PL;
                    end
                    else
                    begin
                        rd_addr = AW'(j_reg - CW'(2));
                    end
                end
                else
                begin
                    state_next = S_PL;
                end
            end
            S_PL:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[AW-1:0];
                wr_data = key_reg;
                i_next  = i_reg + CW'(1);
                if (i_reg + CW'(1) == count_reg)
                begin
                    state_next = S_T0;
                end
                else
                begin
                    state_next = S_RK;
                end
            end
            S_T0:
            begin
                rd_addr    = '0;
                i_next     = '0;
                state_next = S_T1;
            end
            S_T1:
            begin
                key_next   = rd_data;
                rd_addr    = AW'(1);
                state_next = S_T2;
            end
            S_T2:
            begin
                // cap the held row at the next start, then slide the window
                if (rd_data.start < key_reg.limit)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = i_reg[AW-1:0];
                    wr_data       = key_reg;
                    wr_data.limit = rd_data.start;
                end
                key_next = rd_data;
                i_next   = i_reg + CW'(1);
                if (i_reg + CW'(2) < count_reg)
                begin
                    rd_addr = AW'(i_reg + CW'(2));
                end
                else
                begin
                    pub_next   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_L0:
            begin
                if (addr_reg < rd_data.start)
                begin
                    res_next.status = arsl_pkg::ST_MISS;
                    state_next      = S_DONE;
                end
                else
                begin
                    key_next = rd_data;
                    if (lo_reg < hi_reg)
                    begin
                        rd_addr    = nmid;
                        mid_next   = nmid;
                        state_next = S_LC;
                    end
                    else
                    begin
                        state_next = S_LF;
                    end
                end
            end
            S_LC:
            begin
                if (rd_data.start <= addr_reg)
                begin
                    key_next = rd_data;
                end
                lo_next = nlo;
                hi_next = nhi;
                if (nlo < nhi)
                begin
                    rd_addr  = nmid;
                    mid_next = nmid;
                end
                else
                begin
                    state_next = S_LF;
                end
            end
            S_LF:
            begin
                if (addr_reg >= key_reg.limit)
                begin
                    res_next.status = arsl_pkg::ST_MISS;
                end
                else if (key_reg.name >= strings_size)
                begin
                    res_next.status = arsl_pkg::ST_BADNAME;
                end
                else
                begin
                    res_next.status     = arsl_pkg::ST_OK;
                    res_next.hit_name   = key_reg.name;
                    res_next.hit_offset = addr_reg - key_reg.start;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pub_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pub_reg   <= pub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign res  = res_reg;

endmodule

@@ sv/address_range_symbol_lookup.sv @@
// address_range_symbol_lookup: top level, stream ports, config and output register.
// Depends on arsl_pkg and arsl_engine.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_tvalid / s_tready       s_tuser cmd, s_tdata row and query fields
//  m_axis    out  m_tvalid / m_tready       m_tdata status, hit_name, hit_offset
//  cfg       in   cfg_valid / cfg_ready     cfg_data strings_size
//
// Lookup does one read of the row memory (one read and one write port) per
// search step. Finalize runs an insertion sort over the same memory, then one
// pass to cap limits. Reset (rst_n low, async) empties the table. A result
// waits in the output register while the next request is taken.
module address_range_symbol_lookup #(
    parameter int MAX_ROWS = arsl_pkg::DEFAULT_MAX_ROWS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // cmd
    input  logic [223:0] s_tdata,   // row_start, row_section_end, row_name, query_address
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // status, hit_name, hit_offset, zero pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data   // strings_size
);
    logic [31:0]    ssize_reg;
    logic           ovalid_reg;
    arsl_pkg::res_t ores_reg;
    arsl_pkg::req_t req;
    arsl_pkg::res_t eng_res;
    logic           eng_busy;
    logic           eng_done;
    logic           slot_free;

    assign req.cmd             = s_tuser;
    assign req.row_start       = s_tdata[63:0];
    assign req.row_section_end = s_tdata[127:64];
    assign req.row_name        = s_tdata[159:128];
    assign req.query_address   = s_tdata[223:160];

    assign s_tready  = !eng_busy;
    assign cfg_ready = 1'b1;
    assign slot_free = !ovalid_reg || m_tready;

    arsl_engine #(
        .MAX_ROWS (MAX_ROWS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (s_tvalid && s_tready),
        .req          (req),
        .strings_size (ssize_reg),
        .slot_free    (slot_free),
        .busy         (eng_busy),
        .done         (eng_done),
        .res          (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssize_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                ssize_reg <= cfg_data;
            end
            if (eng_done)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            ores_reg <= eng_res;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'd0, ores_reg};

endmodule

@@ bench/tb_address_range_symbol_lookup.sv @@
// Testbench for address_range_symbol_lookup: table clear, load, finalize and floor lookup
// checked against an in-bench predictor under random stream idling. Depends on arsl_pkg.
`timescale 1ns / 100ps

module tb_address_range_symbol_lookup;

    localparam int ROWS = arsl_pkg::DEFAULT_MAX_ROWS;
    localparam int CYCLE_LIMIT = 3_000_000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser = '0;
    logic [223:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;

    address_range_symbol_lookup #(.MAX_ROWS(ROWS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor copy of the table
    logic [63:0] tbl_start [ROWS];
    logic [63:0] tbl_limit [ROWS];
    logic [31:0] tbl_name  [ROWS];
    int          tbl_rows = 0;
    bit          tbl_live = 1'b0;
    logic [31:0] name_bound = '0;

    arsl_pkg::res_t expected_results [$];
    int   failures = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_request = 0;
    int   hold_left = 0;
    longint cycle_count = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic arsl_pkg::res_t lookup_result(logic [63:0] addr);
        arsl_pkg::res_t r;
        int lo;
        int hi;
        int mid;
        r = '0;
        r.status = arsl_pkg::ST_MISS;
        if (!tbl_live || tbl_rows == 0 || addr < tbl_start[0])
            return r;
        lo = 0;
        hi = tbl_rows - 1;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            if (tbl_start[mid] <= addr)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (addr >= tbl_limit[lo])
            return r;
        if (tbl_name[lo] >= name_bound)
        begin
            r.status = arsl_pkg::ST_BADNAME;
            return r;
        end
        r.status = arsl_pkg::ST_OK;
        r.hit_name = tbl_name[lo];
        r.hit_offset = addr - tbl_start[lo];
        return r;
    endfunction

    function automatic arsl_pkg::res_t table_result(arsl_pkg::req_t q);
        arsl_pkg::res_t r;
        logic [63:0] s;
        logic [63:0] l;
        logic [31:0] nm;
        int j;
        r = '0;
        r.status = arsl_pkg::ST_OK;
        case (q.cmd)
            arsl_pkg::CMD_CLEAR:
            begin
                tbl_rows = 0;
                tbl_live = 1'b0;
            end
            arsl_pkg::CMD_LOAD:
            begin
                if (tbl_rows >= ROWS)
                    r.status = arsl_pkg::ST_FULL;
                else
                begin
                    tbl_start[tbl_rows] = q.row_start;
                    tbl_limit[tbl_rows] = q.row_section_end;
                    tbl_name[tbl_rows] = q.row_name;
                    tbl_rows++;
                    tbl_live = 1'b0;
                end
            end
            arsl_pkg::CMD_FINAL:
            begin
                if (tbl_rows == 0)
                begin
                    tbl_live = 1'b0;
                    r.status = arsl_pkg::ST_EMPTY;
                end
                else
                begin
                    // stable insertion sort, then cap each limit at the next start
                    for (int i = 1; i < tbl_rows; i++)
                    begin
                        s = tbl_start[i];
                        l = tbl_limit[i];
                        nm = tbl_name[i];
                        j = i;
                        while (j > 0 && tbl_start[j - 1] > s)
                        begin
                            tbl_start[j] = tbl_start[j - 1];
                            tbl_limit[j] = tbl_limit[j - 1];
                            tbl_name[j] = tbl_name[j - 1];
                            j--;
                        end
                        tbl_start[j] = s;
                        tbl_limit[j] = l;
                        tbl_name[j] = nm;
                    end
                    for (int i = 0; i + 1 < tbl_rows; i++)
                        if (tbl_start[i + 1] < tbl_limit[i])
                            tbl_limit[i] = tbl_start[i + 1];
                    tbl_live = 1'b1;
                end
            end
            default:
                r = lookup_result(q.query_address);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycle_count);
        failures++;
    endtask

    // receiver: random ready, long hold-offs, result check
    always @(posedge clk)
    begin
        arsl_pkg::res_t got;
        arsl_pkg::res_t want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[98:0];
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 64'(got.status), 64'd0);
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.hit_name !== want.hit_name)
                    report_mismatch("hit_name", 64'(got.hit_name), 64'(want.hit_name));
                if (got.hit_offset !== want.hit_offset)
                    report_mismatch("hit_offset", got.hit_offset, want.hit_offset);
            end
        end
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(arsl_pkg::req_t q);
        // idle the sender cycle by cycle
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= q.cmd;
        s_tdata <= {q.query_address, q.row_name, q.row_section_end, q.row_start};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(table_result(q));
    endtask

    function automatic arsl_pkg::req_t make_req(logic [1:0] cmd, logic [63:0] start,
                                                logic [63:0] send, logic [31:0] name,
                                                logic [63:0] query);
        arsl_pkg::req_t q;
        q.cmd = cmd;
        q.row_start = start;
        q.row_section_end = send;
        q.row_name = name;
        q.query_address = query;
        return q;
    endfunction

    task automatic send_cmd(logic [1:0] cmd);
        send_request(make_req(cmd, rand64(), rand64(), $urandom, rand64()));
    endtask

    task automatic send_row(logic [63:0] start, logic [63:0] send, logic [31:0] name);
        send_request(make_req(arsl_pkg::CMD_LOAD, start, send, name, rand64()));
    endtask

    task automatic send_lookup(logic [63:0] addr);
        send_request(make_req(arsl_pkg::CMD_LOOKUP, rand64(), rand64(), $urandom, addr));
    endtask

    // pause the sender until every result is back, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_strings_size(logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        name_bound = value;
    endtask

    task automatic test_directed();
        write_strings_size(32'h0000_1000);
        send_lookup(64'h10);                      // nothing published
        send_cmd(arsl_pkg::CMD_FINAL);            // empty finalize
        send_row(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_row(64'h1000, 64'h2000, 32'h10);
        send_row(64'h1000, 64'h3000, 32'h20);     // equal start, later load wins
        send_row(64'h0, 64'h0, 32'h30);           // empty section
        send_row(64'h5000, 64'h4000, 32'h40);     // end below start
        send_row(64'h8000, 64'h9000, 32'hFFFF_FFFF); // malformed name
        send_lookup(64'h10);                      // loaded but not published
        send_cmd(arsl_pkg::CMD_FINAL);
        send_cmd(arsl_pkg::CMD_FINAL);            // repeat changes nothing
        send_lookup(64'h0);
        send_lookup(64'h1000);
        send_lookup(64'h2FFF);
        send_lookup(64'h3000);
        send_lookup(64'h5000);
        send_lookup(64'h8004);
        send_lookup(64'hFFFF_FFFF_FFFF_FFFF);
        send_row(64'h100, 64'h200, 32'h1);        // unpublishes
        send_lookup(64'h1000);
        send_cmd(arsl_pkg::CMD_FINAL);
        send_lookup(64'h180);
        send_cmd(arsl_pkg::CMD_CLEAR);
        send_lookup(64'h180);
        write_strings_size(32'hFFFF_FFFF);
        send_row(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFE);
        send_cmd(arsl_pkg::CMD_FINAL);
        send_lookup(64'hFFFF_FFFF_FFFF_FFFE);
        write_strings_size(32'h0);
        send_lookup(64'h1);                       // every name malformed now
    endtask

    task automatic test_table_full();
        send_cmd(arsl_pkg::CMD_CLEAR);
        for (int i = 0; i < ROWS; i++)
            send_row(64'(i) * 64'h100, 64'(i) * 64'h100 + 64'h80, 32'(i));
        send_row(64'h0, 64'h10, 32'h0);           // refused
        send_cmd(arsl_pkg::CMD_CLEAR);
        drain();
    endtask

    task automatic random_table_round();
        logic [63:0] base;
        int n;
        base = ($urandom_range(7) == 0) ? 64'hFFFF_FFFF_FFFF_F000 : rand64();
        n = ($urandom_range(15) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
        if ($urandom_range(9) == 0)
            send_cmd(arsl_pkg::CMD_FINAL);        // noise: finalize over stale state
        send_cmd(arsl_pkg::CMD_CLEAR);
        for (int i = 0; i < n; i++)
        begin
            logic [63:0] s;
            s = ($urandom_range(5) == 0 && i > 0) ? tbl_start[tbl_rows - 1]
                                                  : base + $urandom_range(0, 4096);
            send_row(s, ($urandom_range(9) == 0) ? rand64() : s + $urandom_range(0, 600),
                     ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 1024));
        end
        if ($urandom_range(9) == 0)
            send_lookup(base + $urandom_range(0, 4096)); // before publish
        send_cmd(arsl_pkg::CMD_FINAL);
        repeat ($urandom_range(4, 14))
        begin
            if ($urandom_range(5) == 0)
                send_lookup(rand64());
            else
                send_lookup(tbl_start[$urandom_range(0, tbl_rows - 1)]
                            + $urandom_range(0, 700) - 64'd20);
        end
        if ($urandom_range(11) == 0)
        begin
            send_cmd(arsl_pkg::CMD_LOAD);         // load after publish: lookups miss
            send_lookup(base);
        end
    endtask

    task automatic test_random(int items, int send_pct, int recv_pct);
        int start_count;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_count = 0;
        while (start_count < items)
        begin
            random_table_round();
            start_count += 12;
            if ($urandom_range(7) == 0)
                write_strings_size(($urandom_range(2) == 0) ? $urandom : $urandom_range(0, 1100));
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_cmd(arsl_pkg::CMD_CLEAR);
        send_row(64'h4000, 64'h5000, 32'h7);
        send_cmd(arsl_pkg::CMD_FINAL);
        hold_request = 400;
        repeat (30)
            send_lookup(64'h4000 + $urandom_range(0, 8192));
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(400, 33, 54);
        write_strings_size(32'hFFFF_FFFF);
        test_random(400, 54, 33);
        write_strings_size(32'h200);
        test_random(400, 0, 0);
        drain();
        repeat (100) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
sv/arsl_pkg.sv
sv/arsl_engine.sv
sv/address_range_symbol_lookup.sv
bench/tb_address_range_symbol_lookup.sv
